// File: rtl/hjs_pkg.sv
// ---------------------------------------------------------------------------
// hjs_pkg: shared definitions for the heat Jacobi stencil pass unit
// Register indexes, field widths, reset values and the per-item tag that
// travels with each result-producing cell through the arithmetic pipeline and result queue.
// ---------------------------------------------------------------------------
package hjs_pkg;

    // Default structural parameters.
    localparam int MAX_COLS_DEF    = 4096;
    localparam int MAX_ROWS_DEF    = 4096;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths.
    localparam int CNT_W      = 13;
    localparam int COEF_W     = 16;
    localparam int POS_OUT_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Fixed-point format of the coefficients and the rounding bias.
    localparam int FRAC_BITS  = 16;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

    // Result queue depth, in cells.
    localparam int QUEUE_DEPTH = 8;

    // Register reset values: 1024 rows, 1024 columns, 0.125 and 0.11.
    localparam logic [CNT_W-1:0]  ROW_COUNT_RST = 13'd1024;
    localparam logic [CNT_W-1:0]  COL_COUNT_RST = 13'd1024;
    localparam logic [COEF_W-1:0] COEF_X_RST    = 16'd8192;
    localparam logic [COEF_W-1:0] COEF_Y_RST    = 16'd7209;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1,
        REG_COEF_X    = 2'd2,
        REG_COEF_Y    = 2'd3
    } cfg_reg_t;

    // Per-cell control information carried alongside the data.
    typedef struct packed {
        logic                 has_update;  // emits the stencil result of the row above
        logic                 has_echo;    // last row: emits the cell itself as well
        logic                 border;      // updated cell lies on the grid border
        logic                 frame_last;  // very last cell of the frame
        logic [POS_OUT_W-1:0] row;         // row of the arriving cell
        logic [POS_OUT_W-1:0] col;         // column of the arriving cell
    } hjs_tag_t;

endpackage

// File: rtl/hjs_ram.sv
// ---------------------------------------------------------------------------
// hjs_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// Contents are undefined until written.
// ---------------------------------------------------------------------------
module hjs_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write first in code order, but a read sees the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/hjs_stencil_pipe.sv
// ---------------------------------------------------------------------------
// hjs_stencil_pipe: three-stage five-point stencil arithmetic
// Stage A captures the neighbourhood, stage B forms the two second
// differences, stage C holds the two coefficient products. The final sum,
// rounding and saturation are combinational after stage C.
// ---------------------------------------------------------------------------
module hjs_stencil_pipe
    import hjs_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic        [COEF_W-1:0]      coef_x,
    input  logic        [COEF_W-1:0]      coef_y,
    input  logic signed [VALUE_WIDTH-1:0] center_val,
    input  logic signed [VALUE_WIDTH-1:0] up_val,
    input  logic signed [VALUE_WIDTH-1:0] down_val,
    input  logic signed [VALUE_WIDTH-1:0] left_val,
    input  logic signed [VALUE_WIDTH-1:0] right_val,
    input  hjs_tag_t                      tag_in,
    output logic [1:0]                    busy,
    output logic                          out_valid,
    output logic signed [VALUE_WIDTH-1:0] result,
    output logic signed [VALUE_WIDTH-1:0] pass_value,
    output hjs_tag_t                      tag_out
);

    localparam int VW  = VALUE_WIDTH;
    localparam int LW  = VW + 2;             // second difference
    localparam int PRW = LW + COEF_W + 1;    // coefficient product
    localparam int ACW = PRW + 2;            // accumulated sum
    localparam int QW  = ACW - FRAC_BITS;    // sum after the fraction is dropped

    // Stage A: captured neighbourhood.
    logic                 vld_a_reg;
    logic signed [VW-1:0] c_a_reg, u_a_reg, d_a_reg, l_a_reg, r_a_reg;
    hjs_tag_t             tag_a_reg;

    // Stage B: second differences.
    logic                 vld_b_reg;
    logic signed [VW-1:0] c_b_reg, d_b_reg;
    logic signed [LW-1:0] lapx_b_reg, lapy_b_reg;
    hjs_tag_t             tag_b_reg;

    // Stage C: coefficient products.
    logic                  vld_c_reg;
    logic signed [VW-1:0]  c_c_reg, d_c_reg;
    logic signed [PRW-1:0] px_c_reg, py_c_reg;
    hjs_tag_t              tag_c_reg;

    logic signed [LW-1:0]  lapx_next, lapy_next;
    logic signed [PRW-1:0] px_next, py_next;
    logic signed [ACW-1:0] acc;
    logic        [QW-1:0]  quot;
    logic        [QW-VW:0] quot_top;
    logic signed [VW-1:0]  sat_val;

    // Second differences: down + up - 2 centre and right + left - 2 centre.
    always_comb
    begin
        lapx_next = LW'(d_a_reg) + LW'(u_a_reg) - (LW'(c_a_reg) <<< 1);
        lapy_next = LW'(r_a_reg) + LW'(l_a_reg) - (LW'(c_a_reg) <<< 1);
    end

    // Coefficients are unsigned Q0.16, widened with a zero sign bit.
    always_comb
    begin
        px_next = PRW'(lapx_b_reg) * PRW'($signed({1'b0, coef_x}));
        py_next = PRW'(lapy_b_reg) * PRW'($signed({1'b0, coef_y}));
    end

    // Sum at scale 2^16, round to nearest with ties upward, then saturate.
    always_comb
    begin
        acc = (ACW'(c_c_reg) <<< FRAC_BITS) + ACW'(px_c_reg) + ACW'(py_c_reg)
              + ACW'(ROUND_BIAS);
        quot     = acc[ACW-1:FRAC_BITS];
        quot_top = quot[QW-1:VW-1];
        if (quot[QW-1] && !(&quot_top))
        begin
            sat_val = {1'b1, {(VW-1){1'b0}}};
        end
        else if (!quot[QW-1] && (|quot_top))
        begin
            sat_val = {1'b0, {(VW-1){1'b1}}};
        end
        else
        begin
            sat_val = quot[VW-1:0];
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    // Stage data; the pipeline never stalls, the queue absorbs back-pressure.
    always_ff @(posedge clk)
    begin
        c_a_reg    <= center_val;
        u_a_reg    <= up_val;
        d_a_reg    <= down_val;
        l_a_reg    <= left_val;
        r_a_reg    <= right_val;
        tag_a_reg  <= tag_in;

        c_b_reg    <= c_a_reg;
        d_b_reg    <= d_a_reg;
        lapx_b_reg <= lapx_next;
        lapy_b_reg <= lapy_next;
        tag_b_reg  <= tag_a_reg;

        c_c_reg    <= c_b_reg;
        d_c_reg    <= d_b_reg;
        px_c_reg   <= px_next;
        py_c_reg   <= py_next;
        tag_c_reg  <= tag_b_reg;
    end

    // Border cells keep their value.
    assign result     = tag_c_reg.border ? c_c_reg : sat_val;
    assign pass_value = d_c_reg;
    assign tag_out    = tag_c_reg;
    assign out_valid  = vld_c_reg;
    assign busy       = {1'b0, vld_a_reg} + {1'b0, vld_b_reg} + {1'b0, vld_c_reg};

endmodule

// File: rtl/hjs_result_queue.sv
// ---------------------------------------------------------------------------
// hjs_result_queue: result queue and output serialiser
// Holds one entry per cell that produces results. An entry yields the
// stencil update of the row above, the echo of a last-row cell, or both in
// that order, one output transaction each.
// ---------------------------------------------------------------------------
module hjs_result_queue
    import hjs_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int DEPTH       = QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic signed [VALUE_WIDTH-1:0] push_update,
    input  logic signed [VALUE_WIDTH-1:0] push_echo,
    input  hjs_tag_t                      push_tag,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] new_value,
    output logic [POS_OUT_W-1:0]          out_row,
    output logic [POS_OUT_W-1:0]          out_col,
    output logic                          last_of_item,
    output logic                          frame_end
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);

    logic signed [VALUE_WIDTH-1:0] update_store_reg [DEPTH];
    logic signed [VALUE_WIDTH-1:0] echo_store_reg   [DEPTH];
    hjs_tag_t                      tag_store_reg    [DEPTH];

    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            half_reg;        // update of the head entry already sent

    hjs_tag_t head_tag;
    logic     send_echo;
    logic     out_xfer;
    logic     pop;

    // Head entry decode: echo follows the update, or stands alone.
    always_comb
    begin
        head_tag     = tag_store_reg[rd_ptr_reg];
        send_echo    = half_reg || !head_tag.has_update;
        out_valid    = (count_reg != '0);
        new_value    = send_echo ? echo_store_reg[rd_ptr_reg] : update_store_reg[rd_ptr_reg];
        out_row      = send_echo ? head_tag.row : head_tag.row - POS_OUT_W'(1);
        out_col      = head_tag.col;
        last_of_item = send_echo || !head_tag.has_echo;
        frame_end    = send_echo && head_tag.frame_last;
        out_xfer     = out_valid && !out_stall;
        pop          = out_xfer && last_of_item;
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            update_store_reg[wr_ptr_reg] <= push_update;
            echo_store_reg[wr_ptr_reg]   <= push_echo;
            tag_store_reg[wr_ptr_reg]    <= push_tag;
        end
    end

    // Pointers, fill count and the serialiser phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (out_xfer)
            begin
                half_reg <= !last_of_item;
            end
        end
    end

    assign count = count_reg;

endmodule

// File: rtl/heat_jacobi_stencil_pass_unit.sv
// ---------------------------------------------------------------------------
// heat_jacobi_stencil_pass_unit: one explicit heat-diffusion step
// Five-point Jacobi stencil over a raster-order grid stream. A line store
// RAM holds the two previous rows, a register holds the left neighbour, and
// each arriving cell releases the update of the cell above it.
//
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid / in_stall     cell_value
//   output   out        out_valid / out_stall   new_value, out_row, out_col,
//                                               last_of_item, frame_end
//   config   in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One cell is taken per clock while in_stall is low; its results pass
// through stages A, B and C and the result queue. Last-row cells produce
// two results each, so there the output side sets the pace. The line store
// is read once per cell, one column ahead of the stream, which keeps the
// single read port enough. After each configuration write the input stalls
// in ST_FETCH_CUR and ST_FETCH_NEXT while the current and next line store
// entries are refetched. Reset clears position, left neighbour and queue;
// the line store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module heat_jacobi_stencil_pass_unit
    import hjs_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] cell_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] new_value,
    output logic [POS_OUT_W-1:0]          out_row,
    output logic [POS_OUT_W-1:0]          out_col,
    output logic                          last_of_item,
    output logic                          frame_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int VW  = VALUE_WIDTH;
    localparam int CPW = $clog2(MAX_COLS);
    localparam int RPW = $clog2(MAX_ROWS);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int OCW = QCW + 2;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FETCH_CUR,
        ST_FETCH_NEXT
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [CNT_W-1:0]  row_count_reg, col_count_reg;
    logic [COEF_W-1:0] coef_x_reg, coef_y_reg;

    // Stream position and neighbourhood registers.
    logic [CPW-1:0]       col_pos_reg;
    logic [RPW-1:0]       row_pos_reg;
    logic signed [VW-1:0] left_reg;
    logic signed [VW-1:0] cur_prev_reg, cur_older_reg;

    logic [31:0]    cols_ext, rows_ext;
    logic [CPW-1:0] cols_m1, eff_c, c_inc, c_base, raddr;
    logic [RPW-1:0] rows_m1, eff_r, r_inc;
    logic           last_c;
    logic           in_acc, cfg_acc;

    logic [2*VW-1:0]      rdata;
    logic signed [VW-1:0] rd_prev, rd_older;

    hjs_tag_t             tag_in, tag_out;
    logic [1:0]           dp_busy;
    logic                 dp_valid;
    logic signed [VW-1:0] dp_result, dp_pass;
    logic [QCW-1:0]       q_count;
    logic [OCW-1:0]       occupancy;

    // Counts clamped to the supported range, held as last index.
    always_comb
    begin
        cols_ext = 32'(col_count_reg);
        rows_ext = 32'(row_count_reg);
        if (cols_ext < 32'd3)
        begin
            cols_m1 = CPW'(2);
        end
        else if (cols_ext > 32'(MAX_COLS))
        begin
            cols_m1 = CPW'(MAX_COLS - 1);
        end
        else
        begin
            cols_m1 = CPW'(cols_ext - 32'd1);
        end
        if (rows_ext < 32'd3)
        begin
            rows_m1 = RPW'(2);
        end
        else if (rows_ext > 32'(MAX_ROWS))
        begin
            rows_m1 = RPW'(MAX_ROWS - 1);
        end
        else
        begin
            rows_m1 = RPW'(rows_ext - 32'd1);
        end
    end

    // Current position; a position beyond a reduced count restarts at zero.
    always_comb
    begin
        eff_c  = (col_pos_reg > cols_m1) ? '0 : col_pos_reg;
        eff_r  = (row_pos_reg > rows_m1) ? '0 : row_pos_reg;
        last_c = (eff_c == cols_m1);
        c_inc  = last_c ? '0 : eff_c + CPW'(1);
        r_inc  = (eff_r == rows_m1) ? '0 : eff_r + RPW'(1);
    end

    // Handshakes; occupancy counts cells in the pipeline and the queue.
    always_comb
    begin
        occupancy = OCW'(q_count) + OCW'(dp_busy);
        in_stall  = (state_reg != ST_RUN) || (occupancy >= OCW'(QUEUE_DEPTH));
        in_acc    = in_valid && !in_stall;
        cfg_ready = 1'b1;
        cfg_acc   = cfg_valid;
    end

    // Line store read address: the entry one column after the next cell, or the current column in ST_FETCH_CUR.
    always_comb
    begin
        c_base = in_acc ? c_inc : eff_c;
        if (state_reg == ST_FETCH_CUR)
        begin
            raddr = eff_c;
        end
        else
        begin
            raddr = (c_base == cols_m1) ? '0 : c_base + CPW'(1);
        end
    end

    // Refetch sequence after a configuration write.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:        state_next = ST_RUN;
            ST_FETCH_CUR:  state_next = ST_FETCH_NEXT;
            ST_FETCH_NEXT: state_next = ST_RUN;
            default:       state_next = ST_RUN;
        endcase
        if (cfg_acc)
        begin
            state_next = ST_FETCH_CUR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
            coef_x_reg    <= COEF_X_RST;
            coef_y_reg    <= COEF_Y_RST;
        end
        else if (cfg_acc)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_COUNT: row_count_reg <= cfg_data[CNT_W-1:0];
                REG_COL_COUNT: col_count_reg <= cfg_data[CNT_W-1:0];
                REG_COEF_X:    coef_x_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_Y:    coef_y_reg    <= cfg_data[COEF_W-1:0];
                default:       ;
            endcase
        end
    end

    // Position counters and the left neighbour.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            left_reg    <= '0;
        end
        else if (in_acc)
        begin
            col_pos_reg <= c_inc;
            row_pos_reg <= last_c ? r_inc : eff_r;
            left_reg    <= cur_prev_reg;
        end
    end

    // Line store entry of the current column, taken from the look-ahead read.
    always_ff @(posedge clk)
    begin
        if (in_acc || (state_reg == ST_FETCH_NEXT))
        begin
            cur_prev_reg  <= rd_prev;
            cur_older_reg <= rd_older;
        end
    end

    // Line store: each entry holds the previous row and the row before it.
    hjs_ram #(
        .WIDTH (2 * VW),
        .DEPTH (MAX_COLS)
    ) u_line_store (
        .clk   (clk),
        .we    (in_acc),
        .waddr (eff_c),
        .wdata ({cell_value, cur_prev_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_prev  = rdata[2*VW-1:VW];
    assign rd_older = rdata[VW-1:0];

    // Control information for the arriving cell.
    always_comb
    begin
        tag_in.has_update = (eff_r != '0);
        tag_in.has_echo   = (eff_r == rows_m1);
        tag_in.border     = (eff_r == RPW'(1)) || (eff_c == '0) || last_c;
        tag_in.frame_last = (eff_r == rows_m1) && last_c;
        tag_in.row        = POS_OUT_W'(eff_r);
        tag_in.col        = POS_OUT_W'(eff_c);
    end

    hjs_stencil_pipe #(
        .VALUE_WIDTH (VW)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_acc && (tag_in.has_update || tag_in.has_echo)),
        .coef_x     (coef_x_reg),
        .coef_y     (coef_y_reg),
        .center_val (cur_prev_reg),
        .up_val     (cur_older_reg),
        .down_val   (cell_value),
        .left_val   (left_reg),
        .right_val  (rd_prev),
        .tag_in     (tag_in),
        .busy       (dp_busy),
        .out_valid  (dp_valid),
        .result     (dp_result),
        .pass_value (dp_pass),
        .tag_out    (tag_out)
    );

    hjs_result_queue #(
        .VALUE_WIDTH (VW),
        .DEPTH       (QUEUE_DEPTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (dp_valid),
        .push_update  (dp_result),
        .push_echo    (dp_pass),
        .push_tag     (tag_out),
        .count        (q_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_value    (new_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_item (last_of_item),
        .frame_end    (frame_end)
    );

endmodule
